@@ rtl/core/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Shared constants, step tables and the block-handoff record.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int WORD_W       = 32;
	localparam int BLOCK_WORDS  = 16;
	localparam int STEPS        = 64;
	localparam int QUEUE_DEPTH  = 2;
	localparam int LEN_W        = 64;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// Byte position where the length field starts.
	localparam logic [5:0] LEN_POS = 6'd56;

	// One full block handed from the front to the back.
	typedef struct packed {
		logic [BLOCK_WORDS*WORD_W-1:0] words;
		logic                          final_blk;
	} md5_blk_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word index for step i.
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		logic [3:0] l;
		l = i[3:0];
		case (i[5:4])
			2'd0: g = l;
			2'd1: g = 4'((l << 2) + l + 4'd1);
			2'd2: g = 4'((l << 1) + l + 4'd5);
			2'd3: g = 4'((l << 3) - l);
			default: g = l;
		endcase
		return g;
	endfunction

endpackage

@@ rtl/core/md5_front.sv @@
// ----------------------------------------------------------------------------
// MD5 front end
// Packs message bytes into blocks, applies padding and length on the last word.
// ----------------------------------------------------------------------------
module md5_front
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	output logic        blk_valid,
	input  logic        blk_stall,
	output md5_blk_t    blk
);

	typedef enum logic [1:0] {FILL, PAD, LEN} state_t;

	state_t                 state_q;
	logic [WORD_W-1:0]      buf_q [BLOCK_WORDS];
	logic [5:0]             pos_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       tot_q;
	logic [31:0]            spill_q;
	logic                   pad80_q;
	logic                   out_v_q;
	logic                   out_fin_q;
	logic [2:0]             cnt;
	logic [6:0]             sum;
	logic                   go;
	logic                   wrap;
	logic                   sent;
	logic [5:0]             bpos [4];
	logic [3:0]             pad_word;

	assign cnt      = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
	assign sum      = 7'(pos_q) + 7'(cnt);
	assign in_stall = (state_q != FILL) || out_v_q;
	assign go       = in_valid && !in_stall;
	assign wrap     = sum[6];
	assign sent     = out_v_q && !blk_stall;
	// Padding writes one word per cycle while no block is pending, from the word with pos_q.
	assign pad_word = pos_q[5:2];
	assign blk_valid = out_v_q;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bpos[b] = pos_q + 6'(b);
		end
	end

	always_comb begin
		for (int w = 0; w < BLOCK_WORDS; w++) begin
			blk.words[w*WORD_W +: WORD_W] = buf_q[w];
		end
		blk.final_blk = out_fin_q;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int b = 0; b < 4; b++) begin
				if (3'(b) < cnt) begin
					if ((7'(pos_q) + 7'(b)) < 7'd64) begin
						buf_q[bpos[b][5:2]][8*bpos[b][1:0] +: 8] <= data_word[8*b +: 8];
					end else begin
						// hold bytes past the block end until the block is sent
						spill_q[8*bpos[b][1:0] +: 8] <= data_word[8*b +: 8];
					end
				end
			end
		end else if (sent) begin
			for (int b = 0; b < 4; b++) begin
				if (6'(b) < pos_q) begin
					buf_q[0][8*b +: 8] <= spill_q[8*b +: 8];
				end
			end
		end else if (state_q == PAD && !out_v_q) begin
			// keep bytes below pos_q, place 0x80 once, zero the rest of the word
			for (int b = 0; b < 4; b++) begin
				if (pad80_q && 2'(b) == pos_q[1:0]) begin
					buf_q[pad_word][8*b +: 8] <= 8'h80;
				end else if (2'(b) >= pos_q[1:0]) begin
					buf_q[pad_word][8*b +: 8] <= 8'h00;
				end
			end
		end else if (state_q == LEN && !out_v_q) begin
			buf_q[BLOCK_WORDS-2] <= tot_q[31:0];
			buf_q[BLOCK_WORDS-1] <= tot_q[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FILL;
			pos_q     <= '0;
			len_q     <= '0;
			tot_q     <= '0;
			pad80_q   <= 1'b0;
			out_v_q   <= 1'b0;
			out_fin_q <= 1'b0;
		end else begin
			if (sent) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				FILL: begin
					if (go) begin
						pos_q <= sum[5:0];
						if (wrap) begin
							out_v_q   <= 1'b1;
							out_fin_q <= 1'b0;
						end
						if (last) begin
							tot_q   <= len_q + LEN_W'({cnt, 3'b000});
							len_q   <= '0;
							pad80_q <= 1'b1;
							state_q <= PAD;
						end else begin
							len_q <= len_q + LEN_W'({cnt, 3'b000});
						end
					end
				end
				PAD: begin
					if (!out_v_q) begin
						pad80_q <= 1'b0;
						pos_q   <= {pad_word + 4'd1, 2'b00};
						if (pad_word == 4'(BLOCK_WORDS-1)) begin
							// no room for the length: send, continue in a new block
							out_v_q   <= 1'b1;
							out_fin_q <= 1'b0;
						end else if (pad_word + 4'd1 == LEN_POS[5:2]) begin
							state_q <= LEN;
						end
					end
				end
				LEN: begin
					if (!out_v_q) begin
						out_v_q   <= 1'b1;
						out_fin_q <= 1'b1;
						pos_q     <= '0;
						state_q   <= FILL;
					end
				end
				default: state_q <= FILL;
			endcase
		end
	end

`ifndef SYNTH
	a_stall_in_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FILL) |-> in_stall)
		else $error("front accepts input while padding");
	a_hold_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && blk_stall) |=> out_v_q)
		else $error("block dropped while stalled");
	a_fin_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_fin_q) |-> $past(state_q) == LEN)
		else $error("final block without length");
`endif

endmodule

@@ rtl/core/md5_queue.sv @@
// ----------------------------------------------------------------------------
// MD5 block queue
// Short FIFO of full blocks between the front end and the compression core.
// ----------------------------------------------------------------------------
module md5_queue
	import md5_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_stall,
	input  md5_blk_t wr_data,
	output logic     rd_valid,
	input  logic     rd_stall,
	output md5_blk_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	md5_blk_t          mem_q [DEPTH];
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic [AW:0]       cnt_q;
	logic              wr;
	logic              rd;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr       = wr_valid && !wr_stall;
	assign rd       = rd_valid && !rd_stall;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

`ifndef SYNTH
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue overflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count slip");
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wp_q == rp_q))
		else $error("queue pointers apart when empty");
`endif

endmodule

@@ rtl/core/md5_core.sv @@
// ----------------------------------------------------------------------------
// MD5 compression core
// One step per cycle over a queued block; emits the digest after a final block.
// ----------------------------------------------------------------------------
module md5_core
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_stall,
	input  md5_blk_t    blk,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	typedef enum logic [1:0] {IDLE, RUN, ADD, EMIT} state_t;

	state_t       state_q;
	logic [31:0]  cv_q [4];
	logic [31:0]  a_q, b_q, c_q, d_q;
	logic [31:0]  w_q [16];
	logic         fin_q;
	logic [5:0]   step_q;
	logic [1:0]   idx_q;
	logic [31:0]  f;
	logic [31:0]  t;
	logic [31:0]  rot;
	logic [4:0]   sh;

	always_comb begin
		case (step_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t   = a_q + f + md5_k(step_q) + w_q[md5_g(step_q)];
		sh  = md5_s(step_q);
		rot = (t << sh) | (t >> (6'd32 - 6'(sh)));
	end

	assign blk_stall   = (state_q != IDLE);
	assign out_valid   = (state_q == EMIT);
	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 2'd3);

	always_ff @(posedge clk) begin
		if (state_q == IDLE && blk_valid) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				w_q[i] <= blk.words[i*WORD_W +: WORD_W];
			end
			fin_q <= blk.final_blk;
			a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
		end else if (state_q == RUN) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
			idx_q   <= '0;
			cv_q[0] <= IV_A; cv_q[1] <= IV_B; cv_q[2] <= IV_C; cv_q[3] <= IV_D;
		end else begin
			case (state_q)
				IDLE: if (blk_valid) begin
					step_q  <= '0;
					state_q <= RUN;
				end
				RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'(STEPS-1)) begin
						state_q <= ADD;
					end
				end
				ADD: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
					idx_q   <= '0;
					state_q <= fin_q ? EMIT : IDLE;
				end
				EMIT: if (!out_stall) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd3) begin
						cv_q[0] <= IV_A; cv_q[1] <= IV_B;
						cv_q[2] <= IV_C; cv_q[3] <= IV_D;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN && step_q == 6'(STEPS-1)) |=> state_q == ADD)
		else $error("compression step count wrong");
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && idx_q != 2'd3) |=> out_valid
			&& idx_q == $past(idx_q) + 1'b1)
		else $error("digest words out of order");
	a_iv_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> cv_q[0] == IV_A)
		else $error("chaining value not restored");
`endif

endmodule

@@ rtl/core/md5_digest_engine.sv @@
// ----------------------------------------------------------------------------
// MD5 digest engine
// Top level: byte packing and padding front end, block queue, compression core.
// ----------------------------------------------------------------------------
// Feed the message as little-endian words (first byte in bits 7:0) with the
// number of valid bytes; only the word marked last may be short or empty. The
// front end packs bytes into 64-byte blocks and takes one word per cycle while
// a block is filling. A full block transfers into a two-entry queue; the core
// runs one MD5 step per cycle, 64 steps plus a load and an add, and the
// sustained input rate is set by this single step unit. On the last word the
// front end writes zero padding and the length, possibly over an extra block,
// waits as needed to hand a block to the queue, and stalls input meanwhile.
// After the final block the core presents A, B, C, D on the output as four
// transfers, then returns to the initial vector.
module md5_digest_engine
	import md5_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	md5_blk_t f_blk, q_blk;
	logic     f_valid, f_stall, q_valid, q_stall;

	// Pack bytes, pad and append the bit length.
	md5_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .data_word, .valid_bytes, .last,
		.blk_valid(f_valid), .blk_stall(f_stall), .blk(f_blk)
	);

	// Decouple block assembly from compression.
	md5_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_blk),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_blk)
	);

	// Run the 64 steps and emit the digest.
	md5_core u_core (
		.clk, .arst_n,
		.blk_valid(q_valid), .blk_stall(q_stall), .blk(q_blk),
		.out_valid, .out_stall, .digest_word, .word_index, .last_word
	);

endmodule
